// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LJC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define LJC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ljc_pkg.sv =====
// ----------------------------------------------------------------------------
// ljc_pkg
// Types, constants and per-cell step functions of the junction classifier.
// ----------------------------------------------------------------------------
package ljc_pkg;

  typedef enum logic [1:0] {
    KIND_CORNER  = 2'd0,
    KIND_TEE     = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_FRONT  = 3'd0,
    OP_SELECT = 3'd1,
    OP_SQRT   = 3'd2,
    OP_DIV    = 3'd3,
    OP_PREP   = 3'd4,
    OP_CORDIC = 3'd5,
    OP_FINAL  = 3'd6
  } op_t;

  localparam int SQRT_STEPS   = 16;
  localparam int DIV_STEPS    = 15;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_BASE    = 2;
  localparam int DIV_BASE     = SQRT_BASE + SQRT_STEPS;
  localparam int PREP_POS     = DIV_BASE + DIV_STEPS;
  localparam int CORDIC_BASE  = PREP_POS + 1;
  localparam int FINAL_POS    = CORDIC_BASE + CORDIC_STEPS;
  localparam int NCELL        = FINAL_POS + 1;

  localparam logic signed [19:0] HALF_PI = 20'sd102944;
  localparam logic signed [20:0] PI_W    = 21'sd205887;
  localparam logic signed [20:0] TWO_PI  = 21'sd411774;

  localparam logic [CORDIC_STEPS-1:0][16:0] ATAN_TAB = {
    17'd2, 17'd4, 17'd8, 17'd16, 17'd32, 17'd64, 17'd128, 17'd256,
    17'd512, 17'd1024, 17'd2047, 17'd4091, 17'd8150, 17'd16055,
    17'd30386, 17'd51472
  };

  typedef struct packed {
    logic [35:0] x;
    logic [35:0] y;
    logic [19:0] z;
  } cvec_t;

  typedef struct packed {
    logic [29:0] rem;
    logic [14:0] q;
  } divs_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [13:0]       px;
    logic [13:0]       py;
    logic [3:0][16:0]  vx;
    logic [3:0][16:0]  vy;
    logic [3:0][31:0]  d;
    logic [16:0]       ax;
    logic [16:0]       ay;
    logic [16:0]       bx;
    logic [16:0]       by;
    logic [31:0]       n1;
    logic [31:0]       n2;
    logic [31:0]       r1;
    logic [31:0]       r2;
    divs_t             dax;
    divs_t             day;
    divs_t             dbx;
    divs_t             dby;
    cvec_t             c;
    cvec_t             o;
    logic              czero;
    logic              ozero;
    logic [15:0]       orient;
  } pipe_t;

  function automatic op_t cell_op(int j);
    op_t r;
    if (j == 0) r = OP_FRONT;
    else if (j == 1) r = OP_SELECT;
    else if (j < DIV_BASE) r = OP_SQRT;
    else if (j < PREP_POS) r = OP_DIV;
    else if (j == PREP_POS) r = OP_PREP;
    else if (j < FINAL_POS) r = OP_CORDIC;
    else r = OP_FINAL;
    return r;
  endfunction

  function automatic int cell_step(int j);
    int r;
    if (j < DIV_BASE) r = j - SQRT_BASE;
    else if (j < PREP_POS) r = j - DIV_BASE;
    else r = j - CORDIC_BASE;
    return r;
  endfunction

  function automatic logic [16:0] abs17(logic [16:0] v);
    return v[16] ? 17'(-v) : v;
  endfunction

  function automatic pipe_t op_front(pipe_t p);
    pipe_t q;
    logic signed [16:0] ex, ey;
    logic signed [33:0] sx, sy;
    q = p;
    for (int k = 0; k < 4; k++) begin
      ex = ($signed(p.vx[k]) <<< 4) - $signed({3'b000, p.px});
      ey = ($signed(p.vy[k]) <<< 4) - $signed({3'b000, p.py});
      sx = ex * ex;
      sy = ey * ey;
      q.vx[k] = ex;
      q.vy[k] = ey;
      q.d[k]  = 32'(sx + sy);
    end
    return q;
  endfunction

  function automatic pipe_t op_select(pipe_t p, logic [7:0] thr);
    pipe_t q;
    logic [11:0] t;
    logic [23:0] t2;
    logic near1, near2;
    logic [1:0] f1, f2, fa;
    q  = p;
    t  = {thr, 4'b0000};
    t2 = t * t;
    near1 = (p.d[0] <= 32'(t2)) || (p.d[1] <= 32'(t2));
    near2 = (p.d[2] <= 32'(t2)) || (p.d[3] <= 32'(t2));
    // on equal distances keep the end point
    f1 = (p.d[0] > p.d[1]) ? 2'd0 : 2'd1;
    f2 = (p.d[2] > p.d[3]) ? 2'd2 : 2'd3;
    fa = near1 ? f1 : f2;
    priority if (near1 && near2) q.kind = KIND_CORNER;
    else if (near1 || near2) q.kind = KIND_TEE;
    else q.kind = KIND_UNKNOWN;
    q.ax = p.vx[fa];
    q.ay = p.vy[fa];
    q.bx = p.vx[f2];
    q.by = p.vy[f2];
    q.n1 = p.d[fa];
    q.n2 = p.d[f2];
    q.r1 = '0;
    q.r2 = '0;
    q.dax.rem = 30'(abs17(p.vx[fa])) << 14;
    q.day.rem = 30'(abs17(p.vy[fa])) << 14;
    q.dbx.rem = 30'(abs17(p.vx[f2])) << 14;
    q.dby.rem = 30'(abs17(p.vy[f2])) << 14;
    q.dax.q = '0;
    q.day.q = '0;
    q.dbx.q = '0;
    q.dby.q = '0;
    return q;
  endfunction

  function automatic logic [63:0] sqrt_one(logic [31:0] n, logic [31:0] r, int i);
    logic [31:0] b, nn, rr;
    b = 32'd1 << (30 - 2 * i);
    if (n >= r + b) begin
      nn = n - (r + b);
      rr = (r >> 1) + b;
    end else begin
      nn = n;
      rr = r >> 1;
    end
    return {nn, rr};
  endfunction

  function automatic pipe_t op_sqrt(pipe_t p, int i);
    pipe_t q;
    q = p;
    {q.n1, q.r1} = sqrt_one(p.n1, p.r1, i);
    {q.n2, q.r2} = sqrt_one(p.n2, p.r2, i);
    return q;
  endfunction

  function automatic divs_t div_one(divs_t s, logic [15:0] len, int i);
    divs_t r;
    logic [30:0] den;
    r   = s;
    den = 31'(len) << i;
    if ({1'b0, s.rem} >= den) begin
      r.rem  = 30'({1'b0, s.rem} - den);
      r.q[i] = 1'b1;
    end
    return r;
  endfunction

  function automatic pipe_t op_div(pipe_t p, int j);
    pipe_t q;
    int i;
    q = p;
    i = DIV_STEPS - 1 - j;
    q.dax = div_one(p.dax, p.r1[15:0], i);
    q.day = div_one(p.day, p.r1[15:0], i);
    q.dbx = div_one(p.dbx, p.r2[15:0], i);
    q.dby = div_one(p.dby, p.r2[15:0], i);
    return q;
  endfunction

  function automatic logic [16:0] unit_comp(logic [16:0] v, logic [14:0] qv,
                                            logic [31:0] len);
    logic [16:0] m;
    m = 17'(qv);
    if (len == '0) return '0;
    return v[16] ? 17'(-m) : m;
  endfunction

  function automatic cvec_t cordic_pre(logic signed [16:0] dx, logic signed [16:0] dy);
    cvec_t c;
    logic signed [35:0] x, y;
    x = 36'(dx) <<< 16;
    y = 36'(dy) <<< 16;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = HALF_PI;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -HALF_PI;
      end
    end else begin
      c.x = x;
      c.y = y;
    end
    return c;
  endfunction

  function automatic pipe_t op_prep(pipe_t p);
    pipe_t q;
    logic signed [16:0] dx, dy, ox, oy;
    q = p;
    if (p.kind == KIND_CORNER) begin
      dx = $signed(unit_comp(p.ax, p.dax.q, p.r1)) + $signed(unit_comp(p.bx, p.dbx.q, p.r2));
      dy = $signed(unit_comp(p.ay, p.day.q, p.r1)) + $signed(unit_comp(p.by, p.dby.q, p.r2));
    end else begin
      dx = $signed(p.ax);
      dy = $signed(p.ay);
    end
    ox = -$signed({3'b000, p.px});
    oy = -$signed({3'b000, p.py});
    q.czero = (dx == 0) && (dy == 0);
    q.ozero = (ox == 0) && (oy == 0);
    q.c = cordic_pre(dx, dy);
    q.o = cordic_pre(ox, oy);
    return q;
  endfunction

  function automatic cvec_t cordic_one(cvec_t c, int i);
    cvec_t r;
    logic signed [35:0] xs, ys;
    xs = $signed(c.x) >>> i;
    ys = $signed(c.y) >>> i;
    if (!c.y[35]) begin
      r.x = $signed(c.x) + ys;
      r.y = $signed(c.y) - xs;
      r.z = $signed(c.z) + $signed({3'b000, ATAN_TAB[i]});
    end else begin
      r.x = $signed(c.x) - ys;
      r.y = $signed(c.y) + xs;
      r.z = $signed(c.z) - $signed({3'b000, ATAN_TAB[i]});
    end
    return r;
  endfunction

  function automatic pipe_t op_cordic(pipe_t p, int i);
    pipe_t q;
    q = p;
    q.c = cordic_one(p.c, i);
    q.o = cordic_one(p.o, i);
    return q;
  endfunction

  function automatic pipe_t op_final(pipe_t p, int frac);
    pipe_t q;
    logic signed [19:0] zc, zo;
    logic signed [20:0] ang;
    logic signed [21:0] half, sum, sh;
    int s;
    q    = p;
    s    = 16 - frac;
    half = (s > 0) ? (22'sd1 <<< (s - 1)) : 22'sd0;
    zc   = p.czero ? 20'sd0 : $signed(p.c.z);
    zo   = p.ozero ? 20'sd0 : $signed(p.o.z);
    ang  = 21'(zc) - 21'(zo);
    if (ang <= -PI_W) ang = ang + TWO_PI;
    if (ang > PI_W) ang = ang - TWO_PI;
    sum = 22'(ang) + half;
    sh  = sum >>> s;
    q.orient = (p.kind == KIND_UNKNOWN) ? 16'd0 : sh[15:0];
    return q;
  endfunction

endpackage

// ===== hw/rtl/ljc_if.sv =====
// ----------------------------------------------------------------------------
// ljc_if
// Valid/ready channels of the junction classifier.
// ----------------------------------------------------------------------------
interface ljc_item_if;
  logic        valid;
  logic        ready;
  logic [13:0] point_x;
  logic [13:0] point_y;
  logic [10:0] first_start_x;
  logic [10:0] first_start_y;
  logic [10:0] first_end_x;
  logic [10:0] first_end_y;
  logic [10:0] second_start_x;
  logic [10:0] second_start_y;
  logic [10:0] second_end_x;
  logic [10:0] second_end_y;

  modport source (output valid, point_x, point_y, first_start_x, first_start_y,
                  first_end_x, first_end_y, second_start_x, second_start_y,
                  second_end_x, second_end_y, input ready);
  modport sink (input valid, point_x, point_y, first_start_x, first_start_y,
                first_end_x, first_end_y, second_start_x, second_start_y,
                second_end_x, second_end_y, output ready);
endinterface

interface ljc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  junction_kind;
  logic [15:0] orientation;

  modport source (output valid, junction_kind, orientation, input ready);
  modport sink (input valid, junction_kind, orientation, output ready);
endinterface

interface ljc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] near_limit;

  modport source (output valid, near_limit, input ready);
  modport sink (input valid, near_limit, output ready);
endinterface

// ===== hw/rtl/line_junction_classifier.sv =====
// ----------------------------------------------------------------------------
// line_junction_classifier
// Classifies a line intersection as corner, T-junction or unknown and
// computes its orientation angle.
// ----------------------------------------------------------------------------
// Channels: item (sink) carries the intersection point and two segments,
// result (source) returns junction_kind and orientation, cfg (sink) writes
// near_limit; cfg is always ready and reads 8 after reset.
// Throughput: one item per cycle is taken continuously while the receiver
// does not stall. The chain holds two front cells (squares, near test),
// 16 square-root cells, 15 divider cells, one setup cell, 16 CORDIC cells
// and one output cell, each holding one register stage. Each cell keeps its
// own valid bit, so bubbles close up: while a result waits on result.ready,
// item.ready stays high until every cell holds an item. Reset empties the
// chain; no item is lost once transferred.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_junction_classifier #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic          clk,
  input  logic          rst,
  ljc_cfg_if.sink       cfg,
  ljc_item_if.sink      item,
  ljc_result_if.source  result
);

  logic [7:0]     threshold;
  ljc_pkg::pipe_t item_data;
  logic           cell_valid [ljc_pkg::NCELL+1];
  logic           cell_take  [ljc_pkg::NCELL+1];
  ljc_pkg::pipe_t cell_data  [ljc_pkg::NCELL+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 8'd8;
    end else if (cfg.valid) begin
      threshold <= cfg.near_limit;
    end
  end

  always_comb begin
    item_data       = '0;
    item_data.px    = item.point_x;
    item_data.py    = item.point_y;
    item_data.vx[0] = 17'($signed(item.first_start_x));
    item_data.vy[0] = 17'($signed(item.first_start_y));
    item_data.vx[1] = 17'($signed(item.first_end_x));
    item_data.vy[1] = 17'($signed(item.first_end_y));
    item_data.vx[2] = 17'($signed(item.second_start_x));
    item_data.vy[2] = 17'($signed(item.second_start_y));
    item_data.vx[3] = 17'($signed(item.second_end_x));
    item_data.vy[3] = 17'($signed(item.second_end_y));
  end

  assign cell_data[0]              = item_data;
  assign cell_valid[0]             = item.valid;
  assign item.ready                = cell_take[0];
  assign cell_take[ljc_pkg::NCELL] = result.ready;

  for (genvar j = 0; j < ljc_pkg::NCELL; j++) begin : g_cell
    ljc_cell #(
      .OP        (ljc_pkg::cell_op(j)),
      .STEP      (ljc_pkg::cell_step(j)),
      .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .thr       (threshold),
      .in_valid  (cell_valid[j]),
      .in_take   (cell_take[j]),
      .in_data   (cell_data[j]),
      .out_valid (cell_valid[j+1]),
      .out_adv   (cell_take[j+1]),
      .out_data  (cell_data[j+1])
    );
  end

  assign result.valid         = cell_valid[ljc_pkg::NCELL];
  assign result.junction_kind = cell_data[ljc_pkg::NCELL].kind;
  assign result.orientation   = cell_data[ljc_pkg::NCELL].orient;

  `LJC_ASSERT_IMP(a_stall_only_full, clk, rst, !item.ready, result.valid && !result.ready)
  `LJC_ASSERT_NXT(a_accept_enters, clk, rst, item.valid && item.ready, cell_valid[1])
  `LJC_ASSERT_IMP(a_unknown_zero, clk, rst, result.valid && (result.junction_kind == ljc_pkg::KIND_UNKNOWN), result.orientation == 16'd0)

endmodule

// ===== hw/rtl/ljc_cell.sv =====
// ----------------------------------------------------------------------------
// ljc_cell
// One registered step of the classifier chain with its own valid/ready flow.
// ----------------------------------------------------------------------------
module ljc_cell #(
  parameter ljc_pkg::op_t OP        = ljc_pkg::OP_FRONT,
  parameter int           STEP      = 0,
  parameter int           FRAC_BITS = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      thr,
  input  logic            in_valid,
  output logic            in_take,
  input  ljc_pkg::pipe_t  in_data,
  output logic            out_valid,
  input  logic            out_adv,
  output ljc_pkg::pipe_t  out_data
);

  ljc_pkg::pipe_t data_next;

  // take a new item whenever the held one leaves or the cell is empty
  assign in_take = !out_valid || out_adv;

  always_comb begin
    unique case (OP)
      ljc_pkg::OP_FRONT:  data_next = ljc_pkg::op_front(in_data);
      ljc_pkg::OP_SELECT: data_next = ljc_pkg::op_select(in_data, thr);
      ljc_pkg::OP_SQRT:   data_next = ljc_pkg::op_sqrt(in_data, STEP);
      ljc_pkg::OP_DIV:    data_next = ljc_pkg::op_div(in_data, STEP);
      ljc_pkg::OP_PREP:   data_next = ljc_pkg::op_prep(in_data);
      ljc_pkg::OP_CORDIC: data_next = ljc_pkg::op_cordic(in_data, STEP);
      ljc_pkg::OP_FINAL:  data_next = ljc_pkg::op_final(in_data, FRAC_BITS);
      default:            data_next = in_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
